// ----- hw/rtl/ifsfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ifsfp_pkg;

    // Field widths of the stream beats
    localparam int PICK_W = 7;
    localparam int ROW_FW = 6;
    localparam int COL_FW = 7;

    // Default bitmap geometry
    localparam int IMG_WIDTH_DEF    = 128;
    localparam int IMG_HEIGHT_DEF   = 48;
    localparam int BITMAP_DEPTH_DEF = (IMG_WIDTH_DEF * IMG_HEIGHT_DEF + 7) / 8;

    // Fixed point and pixel scaling
    localparam int    Q_FRAC      = 24;
    localparam int    RECIP_SHIFT = 24;
    localparam int    COL_DEN     = 11;   // 2.75 = 11/4
    localparam int    ROW_DEN     = 101;  // 10.1 = 101/10
    localparam int    COL_RECIP   = (1 << RECIP_SHIFT) / COL_DEN;
    localparam int    ROW_RECIP   = (1 << RECIP_SHIFT) / ROW_DEN;
    localparam longint COL_OFFSET = longint'(COL_DEN) * (longint'(1) << Q_FRAC);
    localparam longint ROW_OFFSET = longint'(ROW_DEN) * (longint'(1) << Q_FRAC);

    // Pick thresholds for the map choice
    localparam logic [PICK_W-1:0] PICK_STEM       = 7'd0;
    localparam logic [PICK_W-1:0] PICK_LEAF_A_MAX = 7'd7;
    localparam logic [PICK_W-1:0] PICK_LEAF_B_MAX = 7'd14;

    typedef enum logic
    {
        CMD_ITERATE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        MAP_STEM,
        MAP_LEAF_A,
        MAP_LEAF_B,
        MAP_MAIN
    } map_t;

    // All four maps have a zero x offset, so only the y offset is kept
    typedef struct packed
    {
        logic signed [25:0] ax;
        logic signed [25:0] bx;
        logic signed [25:0] ay;
        logic signed [25:0] by;
        logic signed [25:0] cy;
    } map_coef_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MX0,
        ST_MX1,
        ST_MX2,
        ST_MY1,
        ST_MY2,
        ST_SC,
        ST_SR,
        ST_DC,
        ST_DR,
        ST_RD,
        ST_WR,
        ST_PRD,
        ST_PDONE
    } state_t;

    typedef struct packed
    {
        logic rd;
        logic wr;
    } mem_cmd_t;

    function automatic map_coef_t map_coef(input map_t m);
        map_coef_t c;
        case (m)
            MAP_STEM:
            begin
                c = '{ax: 26'sd0, bx: 26'sd0, ay: 26'sd0, by: 26'sd2684355,
                      cy: 26'sd0};
            end
            MAP_LEAF_A:
            begin
                c = '{ax: 26'sd3355443, bx: -26'sd4362076, ay: 26'sd3858760,
                      by: 26'sd3690988, cy: 26'sd26843546};
            end
            MAP_LEAF_B:
            begin
                c = '{ax: -26'sd2516582, bx: 26'sd4697620, ay: 26'sd4362076,
                      by: 26'sd4026532, cy: 26'sd7381975};
            end
            default:
            begin
                c = '{ax: 26'sd14260634, bx: 26'sd671089, ay: -26'sd671089,
                      by: 26'sd14260634, cy: 26'sd26843546};
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ifsfp_bitmap.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ifsfp_bitmap #(
    parameter int DEPTH = ifsfp_pkg::BITMAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ifsfp_pkg::mem_cmd_t      cmd,
    input  logic [AW-1:0]            addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata,
    output logic                     busy
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Sweep zeros through every byte after reset
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign wr_en   = busy_reg || cmd.wr;
    assign wr_addr = busy_reg ? clr_addr_reg : addr;
    assign wr_data = busy_reg ? 8'h00 : wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd && !busy_reg)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ifs_fern_point_plotter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Barnsley fern chaos-game plotter with an on-chip one-bit-per-pixel bitmap.
// Input channel (s_axis_*): one beat per command. tuser carries the command:
// iterate moves the kept point through the affine map chosen by pick, scales
// it to a pixel and sets that pixel; read returns the bit at (row, col).
// Output channel (m_axis_*): exactly one beat per input beat, in order. An
// iterate beat returns pixel_on = 1 and the plotted row and column; a read
// beat returns the stored bit with zero coordinates.
// Rate: one item is in work at a time. From acceptance until its result sits
// in the output register, an iterate makes eight passes through the single
// shared 37x26 multiplier (four map products, two pixel scalings, two
// reciprocal divides), a quotient fix-up and the bitmap read-modify-write.
// A read waits on the registered read of the bitmap memory; tready returns
// in the cycle after the result is loaded.
// Reset: the point returns to (0, 0) and the bitmap is swept to zero one byte
// a cycle over all (IMG_WIDTH*IMG_HEIGHT+7)/8 bytes (768 at the defaults);
// tready stays low for the sweep.
// Stall: the result waits in the output register; a new beat is still taken
// while it waits, and the block holds its final step until the register is
// free.
module ifs_fern_point_plotter #(
    parameter int IMG_WIDTH  = ifsfp_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ifsfp_pkg::IMG_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pick[6:0], row[12:7], col[19:13], zero pad
    input  logic        s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // pixel_on[0], plotted_row[6:1], plotted_col[13:7]
);

    localparam int DEPTH  = (IMG_WIDTH * IMG_HEIGHT + 7) / 8;
    localparam int AW     = $clog2(DEPTH);
    localparam int P_W    = $clog2(IMG_WIDTH * IMG_HEIGHT);
    localparam int COL_W  = $clog2(IMG_WIDTH);
    localparam int ROW_W  = $clog2(IMG_HEIGHT);
    localparam int HALF_W = (IMG_WIDTH - 1) / 2;
    localparam int LAST_R = IMG_HEIGHT - 1;
    localparam int COL_LIM = ifsfp_pkg::COL_DEN * IMG_WIDTH;
    localparam int ROW_LIM = ifsfp_pkg::ROW_DEN * IMG_HEIGHT;
    localparam int U_W    = $clog2((COL_LIM > ROW_LIM) ? COL_LIM : ROW_LIM);
    localparam int RS     = ifsfp_pkg::RECIP_SHIFT;

    // Round half up from Q16.48 products to Q8.24 and saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] s);
        logic signed [63:0] t;
        logic        [39:0] r;
        logic signed [31:0] res;
        t = s + 64'sd8388608;
        r = t[63:24];
        if (!r[39] && (r[39:31] != 9'h000))
        begin
            res = 32'sh7FFFFFFF;
        end
        else if (r[39] && (r[39:31] != 9'h1FF))
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = r[31:0];
        end
        return res;
    endfunction

    // Input beat fields
    logic [6:0]          in_pick;
    logic [5:0]          in_row;
    logic [6:0]          in_col;
    ifsfp_pkg::cmd_t     in_cmd;
    logic                in_fire;
    ifsfp_pkg::map_t     in_map;

    assign in_pick = s_axis_tdata[6:0];
    assign in_row  = s_axis_tdata[12:7];
    assign in_col  = s_axis_tdata[19:13];
    assign in_cmd  = ifsfp_pkg::cmd_t'(s_axis_tuser);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_pick == ifsfp_pkg::PICK_STEM)
        begin
            in_map = ifsfp_pkg::MAP_STEM;
        end
        else if (in_pick <= ifsfp_pkg::PICK_LEAF_A_MAX)
        begin
            in_map = ifsfp_pkg::MAP_LEAF_A;
        end
        else if (in_pick <= ifsfp_pkg::PICK_LEAF_B_MAX)
        begin
            in_map = ifsfp_pkg::MAP_LEAF_B;
        end
        else
        begin
            in_map = ifsfp_pkg::MAP_MAIN;
        end
    end

    // Control
    ifsfp_pkg::state_t   state_reg;
    ifsfp_pkg::state_t   state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                load_out;
    logic                clr_busy;
    ifsfp_pkg::mem_cmd_t mem_cmd;

    // Datapath
    logic signed [31:0]  x_reg;
    logic signed [31:0]  y_reg;
    logic signed [31:0]  nx_reg;
    logic signed [63:0]  acc_reg;
    logic signed [62:0]  mul_reg;
    logic signed [36:0]  mul_a;
    logic signed [25:0]  mul_b;
    ifsfp_pkg::map_t     map_reg;
    ifsfp_pkg::map_coef_t coef;
    logic signed [63:0]  mul_ext;
    logic signed [63:0]  sum_x;
    logic signed [63:0]  sum_y;
    logic signed [36:0]  t_col;
    logic signed [36:0]  t_row;
    logic [38:0]         u_full;
    logic                scale_neg;
    logic [U_W-1:0]      ucol_reg;
    logic [U_W-1:0]      urow_reg;
    logic                col_neg_reg;
    logic                col_hi_reg;
    logic                row_neg_reg;
    logic                row_hi_reg;
    logic [COL_W-1:0]    qest_col;
    logic [ROW_W-1:0]    qest_row;
    logic [U_W-1:0]      rem_col;
    logic [U_W-1:0]      rem_row;
    logic [COL_W-1:0]    col_fix;
    logic [ROW_W-1:0]    row_fix;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [5:0]          rd_row_reg;
    logic [6:0]          rd_col_reg;
    logic                rd_in_range_reg;
    logic                read_path;
    logic [P_W-1:0]      pix_row;
    logic [P_W-1:0]      pix_col;
    logic [P_W-1:0]      pix_p;
    logic [AW-1:0]       mem_addr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    logic                out_pixel_reg;
    logic [5:0]          out_row_reg;
    logic [6:0]          out_col_reg;

    assign coef      = ifsfp_pkg::map_coef(map_reg);
    assign mul_ext   = {mul_reg[62], mul_reg};
    assign sum_x     = acc_reg + mul_ext;
    assign sum_y     = acc_reg + mul_ext + {{14{coef.cy[25]}}, coef.cy, 24'b0};
    // 11*2^24 + 4x and 101*2^24 - 10y
    assign t_col     = 37'(ifsfp_pkg::COL_OFFSET) + {{3{nx_reg[31]}}, nx_reg, 2'b00};
    assign t_row     = 37'(ifsfp_pkg::ROW_OFFSET)
                       - ({{2{y_reg[31]}}, y_reg, 3'b000} + {{4{y_reg[31]}}, y_reg, 1'b0});
    assign u_full    = mul_reg[62:24];
    assign scale_neg = mul_reg[62];

    // Reciprocal quotient is exact or one low; fix with one compare
    assign qest_col = mul_reg[RS +: COL_W];
    assign qest_row = mul_reg[RS +: ROW_W];
    assign rem_col  = ucol_reg - (U_W'(qest_col) * U_W'(ifsfp_pkg::COL_DEN));
    assign rem_row  = urow_reg - (U_W'(qest_row) * U_W'(ifsfp_pkg::ROW_DEN));

    always_comb
    begin
        if (col_neg_reg)
        begin
            col_fix = '0;
        end
        else if (col_hi_reg)
        begin
            col_fix = COL_W'(IMG_WIDTH - 1);
        end
        else if (rem_col >= U_W'(ifsfp_pkg::COL_DEN))
        begin
            col_fix = qest_col + COL_W'(1);
        end
        else
        begin
            col_fix = qest_col;
        end

        if (row_neg_reg)
        begin
            row_fix = '0;
        end
        else if (row_hi_reg)
        begin
            row_fix = ROW_W'(LAST_R);
        end
        else if (rem_row >= U_W'(ifsfp_pkg::ROW_DEN))
        begin
            row_fix = qest_row + ROW_W'(1);
        end
        else
        begin
            row_fix = qest_row;
        end
    end

    // Pixel address: bit p%8 of byte p/8
    assign read_path = (state_reg == ifsfp_pkg::ST_PRD) || (state_reg == ifsfp_pkg::ST_PDONE);
    assign pix_row   = read_path ? P_W'(rd_row_reg) : P_W'(row_reg);
    assign pix_col   = read_path ? P_W'(rd_col_reg) : P_W'(col_reg);
    assign pix_p     = pix_row * P_W'(IMG_WIDTH) + pix_col;
    assign mem_addr  = AW'(pix_p >> 3);
    assign mem_wdata = mem_rdata | (8'b1 << pix_p[2:0]);

    assign out_free = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ifsfp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_cmd == ifsfp_pkg::CMD_READ) ? ifsfp_pkg::ST_PRD
                                                                 : ifsfp_pkg::ST_MX0;
                end
            end
            ifsfp_pkg::ST_MX0:   state_next = ifsfp_pkg::ST_MX1;
            ifsfp_pkg::ST_MX1:   state_next = ifsfp_pkg::ST_MX2;
            ifsfp_pkg::ST_MX2:   state_next = ifsfp_pkg::ST_MY1;
            ifsfp_pkg::ST_MY1:   state_next = ifsfp_pkg::ST_MY2;
            ifsfp_pkg::ST_MY2:   state_next = ifsfp_pkg::ST_SC;
            ifsfp_pkg::ST_SC:    state_next = ifsfp_pkg::ST_SR;
            ifsfp_pkg::ST_SR:    state_next = ifsfp_pkg::ST_DC;
            ifsfp_pkg::ST_DC:    state_next = ifsfp_pkg::ST_DR;
            ifsfp_pkg::ST_DR:    state_next = ifsfp_pkg::ST_RD;
            ifsfp_pkg::ST_RD:    state_next = ifsfp_pkg::ST_WR;
            ifsfp_pkg::ST_WR:
            begin
                if (out_free)
                begin
                    state_next = ifsfp_pkg::ST_IDLE;
                end
            end
            ifsfp_pkg::ST_PRD:   state_next = ifsfp_pkg::ST_PDONE;
            ifsfp_pkg::ST_PDONE:
            begin
                if (out_free)
                begin
                    state_next = ifsfp_pkg::ST_IDLE;
                end
            end
            default:             state_next = ifsfp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, memory port, multiplier operands
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_cmd       = '0;
        load_out      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            ifsfp_pkg::ST_IDLE:
            begin
                s_axis_tready = !clr_busy;
            end
            ifsfp_pkg::ST_MX0:
            begin
                mul_a = {{5{x_reg[31]}}, x_reg};
                mul_b = coef.ax;
            end
            ifsfp_pkg::ST_MX1:
            begin
                mul_a = {{5{y_reg[31]}}, y_reg};
                mul_b = coef.bx;
            end
            ifsfp_pkg::ST_MX2:
            begin
                mul_a = {{5{x_reg[31]}}, x_reg};
                mul_b = coef.ay;
            end
            ifsfp_pkg::ST_MY1:
            begin
                mul_a = {{5{y_reg[31]}}, y_reg};
                mul_b = coef.by;
            end
            ifsfp_pkg::ST_MY2:
            begin
                mul_a = t_col;
                mul_b = 26'(HALF_W);
            end
            ifsfp_pkg::ST_SC:
            begin
                mul_a = t_row;
                mul_b = 26'(LAST_R);
            end
            ifsfp_pkg::ST_SR:
            begin
                mul_a = 37'(ucol_reg);
                mul_b = 26'(ifsfp_pkg::COL_RECIP);
            end
            ifsfp_pkg::ST_DC:
            begin
                mul_a = 37'(urow_reg);
                mul_b = 26'(ifsfp_pkg::ROW_RECIP);
            end
            ifsfp_pkg::ST_RD:
            begin
                mem_cmd.rd = 1'b1;
            end
            ifsfp_pkg::ST_WR:
            begin
                mem_cmd.wr = out_free;
                load_out   = out_free;
            end
            ifsfp_pkg::ST_PRD:
            begin
                mem_cmd.rd = rd_in_range_reg;
            end
            ifsfp_pkg::ST_PDONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifsfp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // Commit the new point once both coordinates are rounded
            if (state_reg == ifsfp_pkg::ST_MY2)
            begin
                x_reg <= nx_reg;
                y_reg <= round_sat(sum_y);
            end
        end
    end

    // Shared multiplier, one product a cycle
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // Payload capture per step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ifsfp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    map_reg         <= in_map;
                    rd_row_reg      <= in_row;
                    rd_col_reg      <= in_col;
                    rd_in_range_reg <= (32'(in_row) < 32'(IMG_HEIGHT))
                                       && (32'(in_col) < 32'(IMG_WIDTH));
                end
            end
            ifsfp_pkg::ST_MX1:
            begin
                acc_reg <= mul_ext;
            end
            ifsfp_pkg::ST_MX2:
            begin
                nx_reg <= round_sat(sum_x);
            end
            ifsfp_pkg::ST_MY1:
            begin
                acc_reg <= mul_ext;
            end
            ifsfp_pkg::ST_SC:
            begin
                col_neg_reg <= scale_neg;
                col_hi_reg  <= (u_full >= 39'(COL_LIM));
                ucol_reg    <= U_W'(u_full);
            end
            ifsfp_pkg::ST_SR:
            begin
                row_neg_reg <= scale_neg;
                row_hi_reg  <= (u_full >= 39'(ROW_LIM));
                urow_reg    <= U_W'(u_full);
            end
            ifsfp_pkg::ST_DC:
            begin
                col_reg <= col_fix;
            end
            ifsfp_pkg::ST_DR:
            begin
                row_reg <= row_fix;
            end
            ifsfp_pkg::ST_WR:
            begin
                if (out_free)
                begin
                    out_pixel_reg <= 1'b1;
                    out_row_reg   <= 6'(row_reg);
                    out_col_reg   <= 7'(col_reg);
                end
            end
            ifsfp_pkg::ST_PDONE:
            begin
                if (out_free)
                begin
                    out_pixel_reg <= rd_in_range_reg && mem_rdata[pix_p[2:0]];
                    out_row_reg   <= '0;
                    out_col_reg   <= '0;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    ifsfp_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (clr_busy)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_pixel_reg};

    // The write half of the read-modify-write always follows its own read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifsfp_pkg::ST_WR) |->
            ($past(state_reg) == ifsfp_pkg::ST_RD || $past(state_reg) == ifsfp_pkg::ST_WR))
        else $error("bitmap write without preceding read");

    // A zero pixel comes only from a read, which reports no coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_pixel_reg) |-> (out_row_reg == 6'd0 && out_col_reg == 7'd0))
        else $error("read beat carries coordinates");

    // A plotted row never leaves the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(out_row_reg) < 32'(IMG_HEIGHT)))
        else $error("plotted row outside bitmap");

    // No beat enters while the bitmap is still being swept
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !(s_axis_tvalid && s_axis_tready))
        else $error("beat accepted during bitmap sweep");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import ifsfp_pkg::*;

    localparam int IMG_W       = IMG_WIDTH_DEF;
    localparam int IMG_H       = IMG_HEIGHT_DEF;
    localparam int RANDOM_N    = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 40;
    localparam longint Q_ONE   = 64'sd16777216;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [PICK_W-1:0] pick;
        logic [ROW_FW-1:0] row;
        logic [COL_FW-1:0] col;
    } fern_cmd_t;

    typedef struct packed
    {
        logic              on;
        logic [ROW_FW-1:0] row;
        logic [COL_FW-1:0] col;
    } pixel_beat_t;

    // Point in Q8.24 plus the whole bitmap, one bit per pixel in raster order
    typedef struct packed
    {
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic [IMG_W*IMG_H-1:0]   pix;
    } fern_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    fern_cmd_t   pending_cmds[$];
    pixel_beat_t expected_pixels[$];
    pixel_beat_t plotted_pixels[$];
    fern_state_t plan_fern;
    fern_state_t live_fern;
    fern_cmd_t   cur_cmd;
    int          total_cmds = 0;
    int          accepted_cmds = 0;
    int          returned_beats = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          run_left = 0;
    int          stall_left = 0;

    ifs_fern_point_plotter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Round half up from Q16.48 to Q8.24 and saturate to 32 bits
    function automatic logic signed [31:0] q24_round(input longint acc);
        longint r;
        r = (acc + 64'sd8388608) >>> 24;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // floor(num / den) for the pixel scale, clamped to 0..maxv
    function automatic int pixel_floor(input longint num, input longint den, input int maxv);
        longint q;
        if (num < 0)
            return 0;
        q = num / den;
        if (q > longint'(maxv))
            return maxv;
        return int'(q);
    endfunction

    // One chaos-game step or one pixel read against the given state
    function automatic pixel_beat_t fern_apply(inout fern_state_t st, input fern_cmd_t fc);
        pixel_beat_t res;
        map_t        m;
        longint      ax, bx, ay, by, cy, accx, accy;
        logic signed [31:0] nx, ny;
        int          r, c;
        res = '0;
        if (fc.cmd == CMD_READ)
        begin
            if (int'(fc.row) < IMG_H && int'(fc.col) < IMG_W)
                res.on = st.pix[int'(fc.row) * IMG_W + int'(fc.col)];
            return res;
        end
        if (fc.pick == PICK_STEM)
            m = MAP_STEM;
        else if (fc.pick <= PICK_LEAF_A_MAX)
            m = MAP_LEAF_A;
        else if (fc.pick <= PICK_LEAF_B_MAX)
            m = MAP_LEAF_B;
        else
            m = MAP_MAIN;
        case (m)
            MAP_STEM:
            begin
                ax = 0;        bx = 0;        ay = 0;        by = 2684355;  cy = 0;
            end
            MAP_LEAF_A:
            begin
                ax = 3355443;  bx = -4362076; ay = 3858760;  by = 3690988;  cy = 26843546;
            end
            MAP_LEAF_B:
            begin
                ax = -2516582; bx = 4697620;  ay = 4362076;  by = 4026532;  cy = 7381975;
            end
            default:
            begin
                ax = 14260634; bx = 671089;   ay = -671089;  by = 14260634; cy = 26843546;
            end
        endcase
        accx = longint'(st.x) * ax + longint'(st.y) * bx;
        accy = longint'(st.x) * ay + longint'(st.y) * by + cy * Q_ONE;
        nx = q24_round(accx);
        ny = q24_round(accy);
        st.x = nx;
        st.y = ny;
        // column: 1 + x/2.75 over 11*2^24, row: 1 - y/10.1 over 101*2^24
        c = pixel_floor(longint'((IMG_W - 1) / 2) * (11 * Q_ONE + 4 * longint'(nx)),
                        11 * Q_ONE, IMG_W - 1);
        r = pixel_floor(longint'(IMG_H - 1) * (101 * Q_ONE - 10 * longint'(ny)),
                        101 * Q_ONE, IMG_H - 1);
        st.pix[r * IMG_W + c] = 1'b1;
        res.on  = 1'b1;
        res.row = r[ROW_FW-1:0];
        res.col = c[COL_FW-1:0];
        return res;
    endfunction

    // Queue a command and track where the plan's own copy of the fern plots
    task automatic add_cmd(input fern_cmd_t fc);
        pixel_beat_t res;
        res = fern_apply(plan_fern, fc);
        if (fc.cmd == CMD_ITERATE)
            plotted_pixels.push_back(res);
        pending_cmds.push_back(fc);
        total_cmds++;
    endtask

    task automatic add_iterate(input int pick);
        fern_cmd_t fc;
        fc      = '0;
        fc.cmd  = CMD_ITERATE;
        fc.pick = pick[PICK_W-1:0];
        add_cmd(fc);
    endtask

    task automatic add_read(input int row, input int col);
        fern_cmd_t fc;
        fc      = '0;
        fc.cmd  = CMD_READ;
        fc.row  = row[ROW_FW-1:0];
        fc.col  = col[COL_FW-1:0];
        add_cmd(fc);
    endtask

    task automatic add_read_plotted(input bit latest);
        pixel_beat_t px;
        if (plotted_pixels.size() == 0)
        begin
            add_read(0, 0);
            return;
        end
        if (latest)
            px = plotted_pixels[$];
        else
            px = plotted_pixels[$urandom_range(0, plotted_pixels.size() - 1)];
        add_read(px.row, px.col);
    endtask

    // Driver: present beats in bursts, log the expected pixel on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_pixels.push_back(fern_apply(live_fern, cur_cmd));
                accepted_cmds++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata  <= {4'b0, cur_cmd.col, cur_cmd.row, cur_cmd.pick};
                    s_tuser  <= cur_cmd.cmd;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // quarter of the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(16, 40);
                        else
                            gap_left = $urandom_range(1, 15);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: runs of ready, then stalls of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            run_left = $urandom_range(1, 30);
            stall_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare each returned beat with the oldest expected pixel
    always @(posedge clk)
    begin
        pixel_beat_t got;
        pixel_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.on  = m_tdata[0];
            got.row = m_tdata[6:1];
            got.col = m_tdata[13:7];
            returned_beats++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected beat on=%0d row=%0d col=%0d, expected none",
                         $time, got.on, got.row, got.col);
                err_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.on !== want.on || got.row !== want.row || got.col !== want.col)
                begin
                    $display("%0t: mismatch expected on=%0d row=%0d col=%0d, actual on=%0d row=%0d col=%0d",
                             $time, want.on, want.row, want.col, got.on, got.row, got.col);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int sel;
        plan_fern = '0;
        live_fern = '0;

        // Directed: empty bitmap, edges of the bitmap, off-bitmap reads
        add_read(0, 0);
        add_read(IMG_H - 1, IMG_W - 1);
        add_read(IMG_H, 0);
        add_read(63, 127);
        add_read(32, 64);
        // every map at the edges of its pick range, picks beyond 99
        add_iterate(0);
        add_read_plotted(1'b1);
        add_iterate(1);
        add_iterate(7);
        add_iterate(8);
        add_iterate(14);
        add_iterate(15);
        add_iterate(99);
        add_iterate(100);
        add_iterate(127);
        add_read_plotted(1'b1);
        add_iterate(50);
        add_iterate(0);
        add_iterate(3);
        add_read_plotted(1'b1);
        add_read_plotted(1'b0);
        add_read(IMG_H - 1, 0);
        add_read(0, IMG_W - 1);

        // Random: mostly real chaos-game steps, with reads biased onto the fern
        for (int i = 0; i < RANDOM_N; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                if ($urandom_range(0, 15) == 0)
                    add_iterate($urandom_range(100, 127));
                else
                    add_iterate($urandom_range(0, 99));
            end
            else if (sel < 80)
                add_read_plotted(1'b0);
            else if (sel < 88)
                add_read_plotted(1'b1);
            else
                add_read($urandom_range(0, 63), $urandom_range(0, 127));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_cmds == total_cmds && returned_beats == accepted_cmds &&
              expected_pixels.size() == 0);
        // hold a little longer to catch stray beats
        repeat (DRAIN_TAIL) @(posedge clk);
        if (err_count == 0 && expected_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ifsfp_pkg.sv
hw/rtl/ifsfp_bitmap.sv
hw/rtl/ifs_fern_point_plotter.sv
dv/testbench.sv
